>>> hw/rtl/matrix_multiply_engine_defines.svh
// assertion macros shared by the matrix multiply engine modules
`ifndef MATRIX_MULTIPLY_ENGINE_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk and disabled during rst
`define MME_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk and disabled during rst
`define MME_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mme_pkg.sv
// shared types and constants of the matrix multiply engine
package mme_pkg;

  localparam int IDX_W     = 3;   // row and column index fields
  localparam int DIM_W     = 4;   // dimension registers
  localparam int CMD_W     = 2;
  localparam int ELEM_IN_W = 16;  // element word on the input port
  localparam int VALUE_W   = 35;  // product element, q19.16
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  // controller to datapath
  typedef struct packed {
    logic             wr_a;    // store the load word into a
    logic             wr_b;    // store the load word into b
    logic             issue;   // one multiply-accumulate step
    logic             first;   // first step of an output element
    logic             last_k;  // last step of an output element
    logic             fin;     // last step of the whole run
    logic             err;     // dimension mismatch marker
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] k;
  } mme_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;  // final word of the run is on the result ports
  } mme_status_t;

  // tag that travels down the datapath pipeline
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_k;
    logic             fin;
    logic             err;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
  } mme_tag_t;

endpackage

>>> hw/rtl/matrix_multiply_engine.sv
// top level of the matrix multiply engine
//
//   channel   handshake                  payload
//   command   start / busy               cmd, elem_row, elem_col, elem_value
//   result    out_strobe (one cycle)     out_row, out_col, out_value, is_last, dim_error
//   config    cfg_we                     cfg_index, cfg_data
//
// a load word does not raise busy; loads may follow back to back
// a compute word holds busy until its last result word is out; the run is paced by the
//   single multiply-accumulate unit that walks the inner dimension, one step a cycle
// a dimension mismatch gives one error word and holds busy until that word is out
// rst is synchronous; the element stores are not cleared and must be loaded first
// results cannot be stalled: each word is shown for exactly one cycle
module matrix_multiply_engine #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // command words
  input  logic                                 start,
  output logic                                 busy,
  input  logic [mme_pkg::CMD_W-1:0]            cmd,
  input  logic [mme_pkg::IDX_W-1:0]            elem_row,
  input  logic [mme_pkg::IDX_W-1:0]            elem_col,
  input  logic signed [mme_pkg::ELEM_IN_W-1:0] elem_value,
  // result words
  output logic                                 out_strobe,
  output logic [mme_pkg::IDX_W-1:0]            out_row,
  output logic [mme_pkg::IDX_W-1:0]            out_col,
  output logic signed [mme_pkg::VALUE_W-1:0]   out_value,
  output logic                                 is_last,
  output logic                                 dim_error,
  // dimension registers
  input  logic                                 cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]            cfg_data
);

  // commands to the datapath, status back
  mme_pkg::mme_cmd_t    dp_cmd;
  mme_pkg::mme_status_t status;

  // sequencing of the row, column and inner loops
  mme_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .elem_row  (elem_row),
    .elem_col  (elem_col),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .dp_cmd    (dp_cmd),
    .busy      (busy)
  );

  // stores, read stage, multiply stage, accumulate and result stage
  mme_dpath #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .dp_cmd     (dp_cmd),
    .elem_row   (elem_row),
    .elem_col   (elem_col),
    .elem_value (elem_value),
    .status     (status),
    .out_strobe (out_strobe),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_value  (out_value),
    .is_last    (is_last),
    .dim_error  (dim_error)
  );

endmodule

>>> hw/rtl/mme_ctrl.sv
// controller: dimension registers, command decode and loop sequencing
`include "matrix_multiply_engine_defines.svh"

module mme_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [mme_pkg::CMD_W-1:0]    cmd,
  input  logic [mme_pkg::IDX_W-1:0]    elem_row,
  input  logic [mme_pkg::IDX_W-1:0]    elem_col,
  input  logic                         cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]    cfg_data,
  input  mme_pkg::mme_status_t         status,
  output mme_pkg::mme_cmd_t            dp_cmd,
  output logic                         busy
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  localparam logic [mme_pkg::DIM_W-1:0] MAX_D = mme_pkg::DIM_W'(MAX_DIM);

  state_t state, state_next;

  logic [mme_pkg::DIM_W-1:0] a_rows, a_cols, b_rows, b_cols;
  logic [mme_pkg::DIM_W-1:0] ar, ac, br, bc;
  logic [mme_pkg::IDX_W-1:0] r, c, k;
  logic                      mismatch;
  logic                      accept, in_range, k_end, c_end, r_end, run_fin;

  function automatic logic [mme_pkg::DIM_W-1:0] clamp_dim(
    input logic [mme_pkg::DIM_W-1:0] d
  );
    logic [mme_pkg::DIM_W-1:0] res;
    res = d;
    if (d == '0) begin
      res = mme_pkg::DIM_W'(1);
    end else if (d > MAX_D) begin
      res = MAX_D;
    end
    return res;
  endfunction

  assign ar = clamp_dim(a_rows);
  assign ac = clamp_dim(a_cols);
  assign br = clamp_dim(b_rows);
  assign bc = clamp_dim(b_cols);

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = ({1'b0, elem_row} < MAX_D) && ({1'b0, elem_col} < MAX_D);

  assign k_end   = ({1'b0, k} == ac - mme_pkg::DIM_W'(1));
  assign c_end   = ({1'b0, c} == bc - mme_pkg::DIM_W'(1));
  assign r_end   = ({1'b0, r} == ar - mme_pkg::DIM_W'(1));
  assign run_fin = mismatch || (k_end && c_end && r_end);

  // dimension registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= mme_pkg::DIM_RESET;
      a_cols <= mme_pkg::DIM_RESET;
      b_rows <= mme_pkg::DIM_RESET;
      b_cols <= mme_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mme_pkg::REG_A_ROWS: a_rows <= cfg_data;
        mme_pkg::REG_A_COLS: a_cols <= cfg_data;
        mme_pkg::REG_B_ROWS: b_rows <= cfg_data;
        mme_pkg::REG_B_COLS: b_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && cmd == mme_pkg::CMD_COMPUTE) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (run_fin) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      r        <= '0;
      c        <= '0;
      k        <= '0;
      mismatch <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        r        <= '0;
        c        <= '0;
        k        <= '0;
        mismatch <= (ac != br);
      end else if (state == ST_RUN) begin
        if (!k_end) begin
          k <= k + 1'b1;
        end else begin
          k <= '0;
          if (!c_end) begin
            c <= c + 1'b1;
          end else begin
            c <= '0;
            r <= r + 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    dp_cmd        = '0;
    dp_cmd.wr_a   = accept && (cmd == mme_pkg::CMD_LOAD_A) && in_range;
    dp_cmd.wr_b   = accept && (cmd == mme_pkg::CMD_LOAD_B) && in_range;
    dp_cmd.issue  = (state == ST_RUN);
    dp_cmd.first  = (k == '0);
    dp_cmd.last_k = k_end;
    dp_cmd.fin    = run_fin;
    dp_cmd.err    = mismatch;
    dp_cmd.r      = r;
    dp_cmd.c      = c;
    dp_cmd.k      = k;
  end

  `MME_ASSERT_NOW(a_done_in_drain, status.done, state == ST_DRAIN, "done outside drain")
  `MME_ASSERT_NEXT(a_compute_runs, accept && cmd == mme_pkg::CMD_COMPUTE, state == ST_RUN, "compute did not start")
  `MME_ASSERT_NOW(a_no_load_busy, dp_cmd.wr_a || dp_cmd.wr_b, state == ST_IDLE, "load while busy")

endmodule

>>> hw/rtl/mme_dpath.sv
// datapath: element stores, multiplier, accumulator and result registers
`include "matrix_multiply_engine_defines.svh"

module mme_dpath #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mme_pkg::mme_cmd_t                  dp_cmd,
  input  logic [mme_pkg::IDX_W-1:0]          elem_row,
  input  logic [mme_pkg::IDX_W-1:0]          elem_col,
  input  logic signed [mme_pkg::ELEM_IN_W-1:0] elem_value,
  output mme_pkg::mme_status_t               status,
  output logic                               out_strobe,
  output logic [mme_pkg::IDX_W-1:0]          out_row,
  output logic [mme_pkg::IDX_W-1:0]          out_col,
  output logic signed [mme_pkg::VALUE_W-1:0] out_value,
  output logic                               is_last,
  output logic                               dim_error
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LIN_W  = 2 * mme_pkg::IDX_W + 1;
  localparam int PROD_W = 2 * ELEM_WIDTH;

  logic signed [ELEM_WIDTH-1:0] a_mem [DEPTH];
  logic signed [ELEM_WIDTH-1:0] b_mem [DEPTH];

  logic [ADDR_W-1:0]            wr_addr, addr_a, addr_b;
  logic signed [ELEM_WIDTH-1:0] wr_data;
  logic signed [ELEM_WIDTH-1:0] rd_a, rd_b;
  logic signed [PROD_W-1:0]     prod;
  logic signed [mme_pkg::VALUE_W-1:0] acc, sum;
  mme_pkg::mme_tag_t            tag0, tag1, tag2;

  function automatic logic [ADDR_W-1:0] lin_addr(
    input logic [mme_pkg::IDX_W-1:0] hi,
    input logic [mme_pkg::IDX_W-1:0] lo
  );
    logic [LIN_W-1:0] full;
    full = LIN_W'(hi) * LIN_W'(MAX_DIM) + LIN_W'(lo);
    return full[ADDR_W-1:0];
  endfunction

  assign wr_addr = lin_addr(elem_row, elem_col);
  assign wr_data = ELEM_WIDTH'(elem_value);
  assign addr_a  = lin_addr(dp_cmd.r, dp_cmd.k);
  assign addr_b  = lin_addr(dp_cmd.k, dp_cmd.c);

  always_comb begin
    tag0.valid  = dp_cmd.issue;
    tag0.first  = dp_cmd.first;
    tag0.last_k = dp_cmd.last_k;
    tag0.fin    = dp_cmd.fin;
    tag0.err    = dp_cmd.err;
    tag0.r      = dp_cmd.r;
    tag0.c      = dp_cmd.c;
  end

  // stores, one write or one read each per cycle
  always_ff @(posedge clk) begin
    if (dp_cmd.wr_a) begin
      a_mem[wr_addr] <= wr_data;
    end
    if (dp_cmd.wr_b) begin
      b_mem[wr_addr] <= wr_data;
    end
    if (dp_cmd.issue) begin
      rd_a <= a_mem[addr_a];
      rd_b <= b_mem[addr_b];
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    prod <= rd_a * rd_b;
  end

  assign sum = tag2.first ? mme_pkg::VALUE_W'(prod) : acc + mme_pkg::VALUE_W'(prod);

  // accumulate and result stage
  always_ff @(posedge clk) begin
    if (tag2.valid) begin
      acc <= sum;
    end
    out_row   <= tag2.err ? '0 : tag2.r;
    out_col   <= tag2.err ? '0 : tag2.c;
    out_value <= tag2.err ? '0 : sum;
    is_last   <= tag2.fin;
    dim_error <= tag2.err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1       <= '0;
      tag2       <= '0;
      out_strobe <= 1'b0;
    end else begin
      tag1       <= tag0;
      tag2       <= tag1;
      out_strobe <= tag2.valid && (tag2.last_k || tag2.err);
    end
  end

  assign status.done = out_strobe && is_last;

  `MME_ASSERT_NOW(a_err_word, out_strobe && dim_error, is_last && out_value == '0, "bad error word")
  `MME_ASSERT_NEXT(a_quiet_after_last, out_strobe && is_last, !out_strobe, "word after last")
  `MME_ASSERT_NOW(a_err_ends_run, tag2.valid && tag2.err, tag2.fin, "error step not final")

endmodule
